// ----- hw/rtl/bmps_pkg.sv -----
`default_nettype none

package bmps_pkg;

    // mode register, one-hot
    typedef enum logic [2:0] {
        MODE_STANDBY = 3'b001,
        MODE_INFUSE  = 3'b010,
        MODE_STEAM   = 3'b100
    } mode_t;

    // mode codes as seen on the result channel
    localparam logic [1:0] MODE_CODE_STANDBY = 2'd0;
    localparam logic [1:0] MODE_CODE_INFUSE  = 2'd1;
    localparam logic [1:0] MODE_CODE_STEAM   = 2'd2;

    // heater gain sets
    localparam logic [1:0] GAIN_PROP    = 2'd0;
    localparam logic [1:0] GAIN_STANDBY = 2'd1;
    localparam logic [1:0] GAIN_INFUSE  = 2'd2;
    localparam logic [1:0] GAIN_STEAM   = 2'd3;

    // configuration register indexes
    localparam logic [2:0] CFG_BREW_TARGET   = 3'd0;
    localparam logic [2:0] CFG_STEAM_TARGET  = 3'd1;
    localparam logic [2:0] CFG_PUMP_POWER    = 3'd2;
    localparam logic [2:0] CFG_PREINF_TICKS  = 3'd3;
    localparam logic [2:0] CFG_PREINF_MS     = 3'd4;

    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 16;

    // configuration reset values
    localparam logic [11:0] BREW_TARGET_RST  = 12'd300;
    localparam logic [11:0] STEAM_TARGET_RST = 12'd1250;
    localparam logic [7:0]  PUMP_POWER_RST   = 8'd204;
    localparam logic [15:0] PREINF_TICKS_RST = 16'd100;
    localparam logic [15:0] PREINF_MS_RST    = 16'd8000;

    // fixed timing and level constants
    localparam logic [7:0]         PRE_LEVEL        = 8'd153;
    localparam logic [31:0]        RESTART_MS       = 32'd2000;
    localparam logic [31:0]        VALVE_HOLD_MS    = 32'd2000;
    localparam logic [7:0]         STEAM_PUMP_LEVEL = 8'd220;
    localparam logic signed [12:0] STEAM_MARGIN     = 13'sd100;
    localparam logic signed [12:0] ARRIVE_BAND      = 13'sd40;
    localparam logic [31:0]        ARRIVE_HOLDOFF   = 32'd5000;
    localparam logic [3:0]         HEAT_EVERY       = 4'd12;

    // reciprocal precision for the ramp division
    localparam int RECIP_SHIFT = 24;

    // result fields carried down the pipeline
    typedef struct packed {
        logic [7:0]         pump_level;
        logic               pump_write;
        logic               valve_open;
        logic [1:0]         mode;
        logic signed [11:0] target_temp;
        logic [1:0]         gain_set;
        logic               gain_reload;
        logic               heat_cycle;
        logic               force_full_heat;
        logic               arrived;
    } res_t;

    function automatic logic [1:0] mode_code(input mode_t m);
        logic [1:0] c;
        unique case (m)
            MODE_INFUSE: c = MODE_CODE_INFUSE;
            MODE_STEAM:  c = MODE_CODE_STEAM;
            default:     c = MODE_CODE_STANDBY;
        endcase
        return c;
    endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/brew_mode_pump_sequencer.sv -----
// Brew mode and pump sequencer for a single-boiler espresso machine.
// Input channel (s_valid/s_ready): one control tick per item with time, switch
// levels, flow pulse count and boiler temperatures. Result channel
// (m_valid/m_ready): exactly one item per tick with pump write, valve level,
// mode, heater target, gain set and heater tick flags.
// Configuration: cfg_wr_en with cfg_addr and cfg_wdata writes one register in
// the clock edge, no wait states; the user must write only while the block is
// idle, the block itself does not enforce this. Throughput: one item per clock
// unless a low m_ready stalls the output. The mode/valve/arrival state is
// updated in a single step right behind the input register, so each tick sees
// the state its predecessor left. The ramp level then goes through three more
// stages: elapsed time times power span, reciprocal multiply by 1/RAMP_MS, and
// a remainder correction. Items pass the input register, then stages 1 to 4.
// Reset (aresetn low, synchronous): standby, valve closed, all counters and
// time stamps zero, registers at their power-on values, pipeline empty.
// Stall: when m_ready is low the pipeline stages still fill up behind the
// waiting result; s_ready falls only once every stage holds an item.
`default_nettype none

module brew_mode_pump_sequencer #(
    parameter int RAMP_MS      = 7000,
    parameter int STEAM_PERIOD = 32
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,

    input  wire logic                              cfg_wr_en,
    input  wire logic [bmps_pkg::CFG_ADDR_W-1:0]   cfg_addr,
    input  wire logic [bmps_pkg::CFG_DATA_W-1:0]   cfg_wdata,

    input  wire logic                              s_valid,
    output logic                                   s_ready,
    input  wire logic [31:0]                       s_now_ms,
    input  wire logic                              s_infuse_switch,
    input  wire logic                              s_steam_switch,
    input  wire logic [31:0]                       s_flow_pulses,
    input  wire logic signed [11:0]                s_temp_now,
    input  wire logic signed [11:0]                s_temp_average,

    output logic                                   m_valid,
    input  wire logic                              m_ready,
    output logic [7:0]                             m_pump_level,
    output logic                                   m_pump_write,
    output logic                                   m_valve_open,
    output logic [1:0]                             m_mode,
    output logic signed [11:0]                     m_target_temp,
    output logic [1:0]                             m_gain_set,
    output logic                                   m_gain_reload,
    output logic                                   m_heat_cycle,
    output logic                                   m_force_full_heat,
    output logic                                   m_arrived
);

    localparam int PhW = (STEAM_PERIOD > 1) ? $clog2(STEAM_PERIOD) : 1;
    localparam logic [PhW-1:0] PhLast     = PhW'(STEAM_PERIOD - 1);
    localparam logic [PhW-1:0] PhOff      = PhW'(2);
    localparam logic [31:0]    RampLen    = 32'(RAMP_MS);
    localparam logic [15:0]    RampLen16  = 16'(RAMP_MS);
    localparam logic [24:0]    RampRecip  =
        25'((33'd1 << bmps_pkg::RECIP_SHIFT) / RAMP_MS);

    // ---------------------------------------------------------------
    // configuration registers
    // ---------------------------------------------------------------
    logic signed [11:0] brew_target_reg;
    logic signed [11:0] steam_target_reg;
    logic [7:0]         pump_power_reg;
    logic [15:0]        preinf_ticks_reg;
    logic [15:0]        preinf_ms_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            brew_target_reg  <= bmps_pkg::BREW_TARGET_RST;
            steam_target_reg <= bmps_pkg::STEAM_TARGET_RST;
            pump_power_reg   <= bmps_pkg::PUMP_POWER_RST;
            preinf_ticks_reg <= bmps_pkg::PREINF_TICKS_RST;
            preinf_ms_reg    <= bmps_pkg::PREINF_MS_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                bmps_pkg::CFG_BREW_TARGET:  brew_target_reg  <= cfg_wdata[11:0];
                bmps_pkg::CFG_STEAM_TARGET: steam_target_reg <= cfg_wdata[11:0];
                bmps_pkg::CFG_PUMP_POWER:   pump_power_reg   <= cfg_wdata[7:0];
                bmps_pkg::CFG_PREINF_TICKS: preinf_ticks_reg <= cfg_wdata;
                bmps_pkg::CFG_PREINF_MS:    preinf_ms_reg    <= cfg_wdata;
                default: ;  // writes beyond the register list are dropped
            endcase
        end
    end

    // ---------------------------------------------------------------
    // pipeline handshake: each stage loads when it is empty or moving on
    // ---------------------------------------------------------------
    logic v0_reg, v1_reg, v2_reg, v3_reg, m_valid_reg;
    logic free_out, free3, free2, free1, free0;
    logic take0;

    assign free_out = !m_valid_reg || m_ready;
    assign free3    = !v3_reg || free_out;
    assign free2    = !v2_reg || free3;
    assign free1    = !v1_reg || free2;
    assign free0    = !v0_reg || free1;
    assign take0    = v0_reg && free1;   // tick is processed, state moves on
    assign s_ready  = free0;
    assign m_valid  = m_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v0_reg      <= 1'b0;
            v1_reg      <= 1'b0;
            v2_reg      <= 1'b0;
            v3_reg      <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (free0)    v0_reg      <= s_valid;
            if (free1)    v1_reg      <= v0_reg;
            if (free2)    v2_reg      <= v1_reg;
            if (free3)    v3_reg      <= v2_reg;
            if (free_out) m_valid_reg <= v3_reg;
        end
    end

    // ---------------------------------------------------------------
    // input register
    // ---------------------------------------------------------------
    logic [31:0]        in_now_reg;
    logic               in_inf_reg;
    logic               in_stm_reg;
    logic [31:0]        in_flow_reg;
    logic signed [11:0] in_tnow_reg;
    logic signed [11:0] in_tavg_reg;

    always_ff @(posedge aclk) begin
        if (s_valid && free0) begin
            in_now_reg  <= s_now_ms;
            in_inf_reg  <= s_infuse_switch;
            in_stm_reg  <= s_steam_switch;
            in_flow_reg <= s_flow_pulses;
            in_tnow_reg <= s_temp_now;
            in_tavg_reg <= s_temp_average;
        end
    end

    // ---------------------------------------------------------------
    // sequencer state
    // ---------------------------------------------------------------
    bmps_pkg::mode_t    mode_reg, mode_next;
    logic [31:0]        tick_reg;
    logic [PhW-1:0]     steam_ph_reg, steam_ph_next;
    logic [3:0]         heat_ph_reg, heat_ph_next;
    logic [31:0]        start_reg, start_next;
    logic [31:0]        flow0_reg, flow0_next;
    logic [31:0]        deadline_reg, deadline_next;
    logic               valve_reg, valve_next;
    logic               arr_flag_reg, arr_flag_next;
    logic [31:0]        last_arr_reg, last_arr_next;
    logic [1:0]         gain_reg, gain_next;
    logic signed [11:0] target_reg, target_next;

    // per-tick results of the sequencer step
    logic [7:0]         level_c;
    logic               write_c;
    logic               reload_c;
    logic               heat_c;
    logic               full_c;
    logic               ramp_c;      // level comes from the ramp stages
    logic [15:0]        ramp_e_c;    // ms into the ramp
    logic               span_neg_c;  // final level below preinfusion level
    logic [7:0]         span_mag_c;

    logic [31:0]        t_c, vol_c, e_c;
    logic signed [12:0] steam_thr_c, tnow_x_c, arr_d_c;
    logic signed [8:0]  span_c;
    logic               arr_c;
    logic               tick_wrap_c;

    always_comb begin
        mode_next     = mode_reg;
        gain_next     = gain_reg;
        valve_next    = valve_reg;
        deadline_next = deadline_reg;
        start_next    = start_reg;
        flow0_next    = flow0_reg;
        arr_flag_next = arr_flag_reg;
        last_arr_next = last_arr_reg;
        target_next   = target_reg;
        level_c       = 8'd0;
        write_c       = 1'b0;
        reload_c      = 1'b0;
        heat_c        = 1'b0;
        full_c        = 1'b0;
        ramp_c        = 1'b0;
        t_c           = 32'd0;
        vol_c         = 32'd0;
        e_c           = 32'd0;
        arr_c         = 1'b0;

        steam_thr_c = 13'(signed'(steam_target_reg)) - bmps_pkg::STEAM_MARGIN;
        tnow_x_c    = 13'(signed'(in_tnow_reg));
        arr_d_c     = 13'(signed'(brew_target_reg)) - 13'(signed'(in_tavg_reg));
        span_c      = signed'({1'b0, pump_power_reg}) - signed'({1'b0, bmps_pkg::PRE_LEVEL});
        span_neg_c  = span_c[8];
        span_mag_c  = span_neg_c ? 8'(-span_c) : span_c[7:0];

        // brew switch, ignored in steam mode
        if (mode_reg != bmps_pkg::MODE_STEAM &&
            in_inf_reg != (mode_reg == bmps_pkg::MODE_INFUSE)) begin
            reload_c = 1'b1;
            if (in_inf_reg) begin
                mode_next     = bmps_pkg::MODE_INFUSE;
                gain_next     = bmps_pkg::GAIN_INFUSE;
                valve_next    = 1'b1;
                deadline_next = 32'd0;
                // re-entry within the restart window skips preinfusion
                if (start_reg > in_now_reg - bmps_pkg::RESTART_MS) begin
                    start_next = in_now_reg - {16'd0, preinf_ms_reg};
                end else begin
                    start_next = in_now_reg;
                    flow0_next = in_flow_reg;
                end
            end else begin
                mode_next     = bmps_pkg::MODE_STANDBY;
                target_next   = brew_target_reg;
                gain_next     = bmps_pkg::GAIN_PROP;
                arr_flag_next = 1'b0;
                write_c       = 1'b1;
                deadline_next = in_now_reg + bmps_pkg::VALVE_HOLD_MS;
            end
        end

        // steam switch, ignored while infusing
        if (mode_next != bmps_pkg::MODE_INFUSE &&
            in_stm_reg != (mode_next == bmps_pkg::MODE_STEAM)) begin
            reload_c = 1'b1;
            if (in_stm_reg) begin
                mode_next     = bmps_pkg::MODE_STEAM;
                target_next   = steam_target_reg;
                gain_next     = bmps_pkg::GAIN_STEAM;
                valve_next    = 1'b1;
                deadline_next = 32'd0;
            end else begin
                mode_next     = bmps_pkg::MODE_STANDBY;
                target_next   = brew_target_reg;
                gain_next     = bmps_pkg::GAIN_PROP;
                arr_flag_next = 1'b0;
                level_c       = 8'd0;
                write_c       = 1'b1;
                valve_next    = 1'b0;
            end
        end

        // pump profile
        if (mode_next == bmps_pkg::MODE_INFUSE) begin
            t_c     = in_now_reg - start_next;
            vol_c   = in_flow_reg - flow0_next;
            write_c = 1'b1;
            if (t_c < {16'd0, preinf_ms_reg}) begin
                level_c = (vol_c < {16'd0, preinf_ticks_reg}) ? bmps_pkg::PRE_LEVEL : 8'd0;
            end else begin
                e_c = t_c - {16'd0, preinf_ms_reg};
                if (e_c < RampLen) begin
                    ramp_c = 1'b1;
                end else begin
                    level_c = pump_power_reg;
                end
            end
        end else if (mode_next == bmps_pkg::MODE_STEAM) begin
            // steam pump duty pulse
            if (steam_ph_reg == '0 && tnow_x_c > steam_thr_c) begin
                level_c = bmps_pkg::STEAM_PUMP_LEVEL;
                write_c = 1'b1;
            end else if (steam_ph_reg == PhOff) begin
                level_c = 8'd0;
                write_c = 1'b1;
            end
        end

        // valve closing deadline, zero means none
        if (deadline_next != 32'd0 && in_now_reg > deadline_next) begin
            valve_next = 1'b0;
        end

        // heater tick at heat phase zero, standby arrival on even heat phases
        if (!heat_ph_reg[0]) begin
            if (heat_ph_reg == 4'd0) begin
                heat_c = 1'b1;
                full_c = (mode_next == bmps_pkg::MODE_STEAM) && (tnow_x_c < steam_thr_c);
            end
            if (mode_next == bmps_pkg::MODE_STANDBY) begin
                arr_c = (arr_d_c < bmps_pkg::ARRIVE_BAND) && (arr_d_c > -bmps_pkg::ARRIVE_BAND);
                if (arr_c != arr_flag_next &&
                    (last_arr_reg + bmps_pkg::ARRIVE_HOLDOFF) < in_now_reg) begin
                    arr_flag_next = arr_c;
                    last_arr_next = in_now_reg;
                    gain_next     = arr_c ? bmps_pkg::GAIN_STANDBY : bmps_pkg::GAIN_PROP;
                    reload_c      = 1'b1;
                end
            end
        end

        ramp_e_c = e_c[15:0];
    end

    // phase counters follow the 32 bit tick count, including its wrap
    assign tick_wrap_c   = (tick_reg == '1);
    assign steam_ph_next = (tick_wrap_c || steam_ph_reg == PhLast) ? '0 : steam_ph_reg + PhW'(1);
    assign heat_ph_next  = (tick_wrap_c || heat_ph_reg == bmps_pkg::HEAT_EVERY - 4'd1) ?
                           4'd0 : heat_ph_reg + 4'd1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg     <= bmps_pkg::MODE_STANDBY;
            tick_reg     <= 32'd0;
            steam_ph_reg <= '0;
            heat_ph_reg  <= 4'd0;
            start_reg    <= 32'd0;
            flow0_reg    <= 32'd0;
            deadline_reg <= 32'd0;
            valve_reg    <= 1'b0;
            arr_flag_reg <= 1'b0;
            last_arr_reg <= 32'd0;
            gain_reg     <= bmps_pkg::GAIN_PROP;
            target_reg   <= bmps_pkg::BREW_TARGET_RST;
        end else if (take0) begin
            mode_reg     <= mode_next;
            tick_reg     <= tick_reg + 32'd1;
            steam_ph_reg <= steam_ph_next;
            heat_ph_reg  <= heat_ph_next;
            start_reg    <= start_next;
            flow0_reg    <= flow0_next;
            deadline_reg <= deadline_next;
            valve_reg    <= valve_next;
            arr_flag_reg <= arr_flag_next;
            last_arr_reg <= last_arr_next;
            gain_reg     <= gain_next;
            target_reg   <= target_next;
        end
    end

    // ---------------------------------------------------------------
    // stage 1: sequencer result plus ramp operands
    // ---------------------------------------------------------------
    bmps_pkg::res_t res1_reg, res1_next;
    logic           ramp1_reg, neg1_reg;
    logic [15:0]    e1_reg;
    logic [7:0]     mag1_reg;

    always_comb begin
        res1_next.pump_level      = level_c;
        res1_next.pump_write      = write_c;
        res1_next.valve_open      = valve_next;
        res1_next.mode            = bmps_pkg::mode_code(mode_next);
        res1_next.target_temp     = target_next;
        res1_next.gain_set        = gain_next;
        res1_next.gain_reload     = reload_c;
        res1_next.heat_cycle      = heat_c;
        res1_next.force_full_heat = full_c;
        res1_next.arrived         = arr_flag_next;
    end

    always_ff @(posedge aclk) begin
        if (free1) begin
            res1_reg  <= res1_next;
            ramp1_reg <= ramp_c;
            neg1_reg  <= span_neg_c;
            e1_reg    <= ramp_e_c;
            mag1_reg  <= span_mag_c;
        end
    end

    // ---------------------------------------------------------------
    // stage 2: ramp numerator, elapsed ms times power span magnitude
    // ---------------------------------------------------------------
    bmps_pkg::res_t res2_reg;
    logic           ramp2_reg, neg2_reg;
    logic [23:0]    num2_reg;

    always_ff @(posedge aclk) begin
        if (free2) begin
            res2_reg  <= res1_reg;
            ramp2_reg <= ramp1_reg;
            neg2_reg  <= neg1_reg;
            num2_reg  <= {8'd0, e1_reg} * {16'd0, mag1_reg};
        end
    end

    // ---------------------------------------------------------------
    // stage 3: quotient estimate by reciprocal, low by at most one
    // ---------------------------------------------------------------
    bmps_pkg::res_t res3_reg;
    logic           ramp3_reg, neg3_reg;
    logic [23:0]    num3_reg;
    logic [7:0]     qest3_reg;
    logic [48:0]    recip_prod;

    assign recip_prod = {25'd0, num2_reg} * {24'd0, RampRecip};

    always_ff @(posedge aclk) begin
        if (free3) begin
            res3_reg  <= res2_reg;
            ramp3_reg <= ramp2_reg;
            neg3_reg  <= neg2_reg;
            num3_reg  <= num2_reg;
            qest3_reg <= recip_prod[bmps_pkg::RECIP_SHIFT +: 8];
        end
    end

    // ---------------------------------------------------------------
    // stage 4: remainder correction and final ramp level
    // ---------------------------------------------------------------
    logic [23:0]    qr_c, rem_c, rem_fix_c;
    logic           corr_c;
    logic [7:0]     q_c, q_ceil_c, ramp_level_c;
    bmps_pkg::res_t res_out_next, res_out_reg;

    always_comb begin
        qr_c      = {16'd0, qest3_reg} * {8'd0, RampLen16};
        rem_c     = num3_reg - qr_c;
        corr_c    = (rem_c >= {8'd0, RampLen16});
        rem_fix_c = corr_c ? rem_c - {8'd0, RampLen16} : rem_c;
        q_c       = qest3_reg + {7'd0, corr_c};
        // downward ramp rounds the negative quotient away from zero
        q_ceil_c  = q_c + {7'd0, (rem_fix_c != 24'd0)};
        ramp_level_c = neg3_reg ? bmps_pkg::PRE_LEVEL - q_ceil_c
                                : bmps_pkg::PRE_LEVEL + q_c;
        res_out_next = res3_reg;
        if (ramp3_reg) begin
            res_out_next.pump_level = ramp_level_c;
        end
    end

    always_ff @(posedge aclk) begin
        if (free_out) begin
            res_out_reg <= res_out_next;
        end
    end

    assign m_pump_level      = res_out_reg.pump_level;
    assign m_pump_write      = res_out_reg.pump_write;
    assign m_valve_open      = res_out_reg.valve_open;
    assign m_mode            = res_out_reg.mode;
    assign m_target_temp     = res_out_reg.target_temp;
    assign m_gain_set        = res_out_reg.gain_set;
    assign m_gain_reload     = res_out_reg.gain_reload;
    assign m_heat_cycle      = res_out_reg.heat_cycle;
    assign m_force_full_heat = res_out_reg.force_full_heat;
    assign m_arrived         = res_out_reg.arrived;

endmodule

`default_nettype wire
